@@ rtl/priority_load_shedding_controller_defines.svh @@
// Assertion macros used by the load shedding controller datapath
`ifndef PRIORITY_LOAD_SHEDDING_CONTROLLER_DEFINES_SVH
`define PRIORITY_LOAD_SHEDDING_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define PLSC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define PLSC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/plsc_pkg.sv @@
// Package: types, codes and constants of the load shedding controller
`timescale 1ns / 1ps
package plsc_pkg;

  localparam int MAX_LOADS_DEF  = 16;
  localparam int POWER_BITS_DEF = 16;

  localparam int TOTAL_W = 20;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 20'hFFFFF;
  localparam logic [TOTAL_W-1:0] PLIM_RST  = 20'd5000;
  localparam logic [TOTAL_W-1:0] WLIM_RST  = 20'd4500;

  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_LIMIT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WARNING_LIMIT = 1'd1;

  localparam logic [1:0] OP_CONNECT    = 2'd0;
  localparam logic [1:0] OP_SET_MODE   = 2'd1;
  localparam logic [1:0] OP_DISCONNECT = 2'd2;
  localparam logic [1:0] OP_TICK       = 2'd3;

  localparam logic [1:0] MODE_OFF     = 2'd0;
  localparam logic [1:0] MODE_NORMAL  = 2'd1;
  localparam logic [1:0] MODE_LIMITED = 2'd2;

  localparam logic [1:0] LVL_LOW  = 2'd0;
  localparam logic [1:0] LVL_WARN = 2'd1;
  localparam logic [1:0] LVL_OVER = 2'd2;

  localparam logic [1:0] ERR_OK      = 2'd0;
  localparam logic [1:0] ERR_FULL    = 2'd1;
  localparam logic [1:0] ERR_UNKNOWN = 2'd2;

  localparam logic KIND_CMD    = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] device_id;
    logic [15:0] normal_power;
    logic [15:0] limited_power;
    logic [7:0]  priority_req;
    logic [1:0]  mode;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [15:0]       target_id;
    logic [1:0]        new_mode;
    logic [TOTAL_W-1:0] total_power;
    logic [1:0]        level;
    logic              warning_event;
    logic [1:0]        error;
    logic              last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic latch_in;
    logic walk_clr;
    logic walk_step;
    logic find_step;
    logic apply;
    logic sum_step;
    logic classify;
    logic lim_emit;
    logic scan_step;
    logic shed_emit;
    logic stat_emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic walk_last;
    logic is_tick;
    logic overload;
    logic lim_hit;
    logic over;
    logic best_valid;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/plsc_ctrl.sv @@
// Sequencer of the load shedding controller
`timescale 1ns / 1ps
module plsc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  plsc_pkg::sts_t sts,
  output plsc_pkg::cmd_t cmd
);
  import plsc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_APPLY, S_SUM, S_CLASS, S_LIMIT,
    S_SSUM, S_SCHK, S_SCAN, S_SHED, S_STAT
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          cmd.walk_clr = 1'b1;
          state_nxt    = S_FIND;
        end
      end
      S_FIND: begin
        cmd.find_step = 1'b1;
        cmd.walk_step = 1'b1;
        if (sts.walk_last) state_nxt = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply    = 1'b1;
        cmd.walk_clr = 1'b1;
        state_nxt    = S_SUM;
      end
      S_SUM: begin
        cmd.sum_step  = 1'b1;
        cmd.walk_step = 1'b1;
        if (sts.walk_last) state_nxt = S_CLASS;
      end
      S_CLASS: begin
        cmd.classify = 1'b1;
        cmd.walk_clr = 1'b1;
        state_nxt    = S_STAT;
      end
      S_LIMIT: begin
        if (!sts.lim_hit || sts.out_free) begin
          cmd.lim_emit  = sts.lim_hit;
          cmd.walk_step = 1'b1;
          if (sts.walk_last) begin
            cmd.walk_clr = 1'b1;
            state_nxt    = S_SSUM;
          end
        end
      end
      S_SSUM: begin
        cmd.sum_step  = 1'b1;
        cmd.walk_step = 1'b1;
        if (sts.walk_last) state_nxt = S_SCHK;
      end
      S_SCHK: begin
        cmd.walk_clr = 1'b1;
        state_nxt    = sts.over ? S_SCAN : S_STAT;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.walk_step = 1'b1;
        if (sts.walk_last) state_nxt = S_SHED;
      end
      S_SHED: begin
        if (!sts.best_valid) begin
          state_nxt = S_STAT;
        end else if (sts.out_free) begin
          cmd.shed_emit = 1'b1;
          cmd.walk_clr  = 1'b1;
          state_nxt     = S_SSUM;
        end
      end
      S_STAT: begin
        if (sts.out_free) begin
          cmd.stat_emit = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // a tick that classifies as overload walks the limit pass first
    if (state_r == S_CLASS && sts.is_tick && sts.overload) state_nxt = S_LIMIT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

@@ rtl/plsc_dp.sv @@
// Datapath: load table, power accumulator, ratio compare, result register
`timescale 1ns / 1ps
`include "priority_load_shedding_controller_defines.svh"
module plsc_dp #(
  parameter int MAX_LOADS  = plsc_pkg::MAX_LOADS_DEF,
  parameter int POWER_BITS = plsc_pkg::POWER_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  plsc_pkg::in_item_t             in_data,
  input  logic                           cfg_we,
  input  logic [plsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [plsc_pkg::CFG_W-1:0]     cfg_wdata,
  output logic                           out_valid,
  input  logic                           out_stall,
  output plsc_pkg::out_item_t            out_data,
  input  plsc_pkg::cmd_t                 cmd,
  output plsc_pkg::sts_t                 sts
);
  import plsc_pkg::*;

  localparam int IDX_W  = (MAX_LOADS > 1) ? $clog2(MAX_LOADS) : 1;
  localparam int SUM_W  = ((POWER_BITS > TOTAL_W) ? POWER_BITS : TOTAL_W) + 1;
  localparam int PROD_W = POWER_BITS + 8;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_LOADS - 1);

  logic [15:0]           slot_id_r  [MAX_LOADS];
  logic [POWER_BITS-1:0] slot_np_r  [MAX_LOADS];
  logic [POWER_BITS-1:0] slot_lp_r  [MAX_LOADS];
  logic [7:0]            slot_pri_r [MAX_LOADS];
  logic [1:0]            slot_mode_r[MAX_LOADS];

  logic [TOTAL_W-1:0] plim_r, wlim_r;
  logic [1:0]  op_r, md_r;
  logic [15:0] id_r;
  logic [POWER_BITS-1:0] np_r, lp_r;
  logic [7:0]  pr_r;

  logic [IDX_W-1:0] idx_r;
  logic match_r, free_r;
  logic [IDX_W-1:0] match_idx_r, free_idx_r;
  logic [TOTAL_W-1:0] acc_r, acc_nxt;
  logic [1:0] lvl_r, err_r;
  logic ev_r, latch_r;
  logic best_r;
  logic [IDX_W-1:0] best_idx_r;
  logic [POWER_BITS-1:0] best_pow_r;
  logic [7:0] best_pri_r;
  logic out_valid_r;
  out_item_t out_r;

  logic [15:0] cur_id;
  logic [1:0]  cur_mode;
  logic [7:0]  cur_pri;
  logic [POWER_BITS-1:0] cur_pow;
  logic [TOTAL_W-1:0] acc_base;
  logic [SUM_W-1:0] sum;
  logic [PROD_W-1:0] prod_cur, prod_best;
  logic greater, take;
  logic [IDX_W-1:0] tgt;
  logic [1:0] lvl_new;

  assign cur_id   = slot_id_r[idx_r];
  assign cur_mode = slot_mode_r[idx_r];
  assign cur_pri  = slot_pri_r[idx_r];
  assign cur_pow  = (cur_mode == MODE_NORMAL)  ? slot_np_r[idx_r] :
                    (cur_mode == MODE_LIMITED) ? slot_lp_r[idx_r] : '0;

  // a sum walk restarts at slot zero; the last total holds until the next walk
  assign acc_base = (idx_r == '0) ? '0 : acc_r;
  assign sum     = SUM_W'(acc_base) + SUM_W'(cur_pow);
  assign acc_nxt = (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];

  assign prod_cur  = PROD_W'(cur_pow) * PROD_W'(best_pri_r);
  assign prod_best = PROD_W'(best_pow_r) * PROD_W'(cur_pri);
  always_comb begin
    if (best_pri_r == 8'd0)  greater = 1'b0;
    else if (cur_pri == 8'd0) greater = 1'b1;
    else                      greater = prod_cur > prod_best;
  end
  assign take = (cur_id != 16'd0) && (cur_mode != MODE_OFF) && (!best_r || greater);

  assign tgt = match_r ? match_idx_r : free_idx_r;
  assign lvl_new = (acc_r >= plim_r) ? LVL_OVER : (acc_r >= wlim_r) ? LVL_WARN : LVL_LOW;

  assign sts.walk_last  = (idx_r == IDX_LAST);
  assign sts.is_tick    = (op_r == OP_TICK);
  assign sts.overload   = (lvl_new == LVL_OVER);
  assign sts.lim_hit    = (cur_id != 16'd0) && (cur_mode == MODE_NORMAL);
  assign sts.over       = (acc_r >= plim_r);
  assign sts.best_valid = best_r;
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_LOADS; i++) begin
        slot_id_r[i]   <= '0;
        slot_np_r[i]   <= '0;
        slot_lp_r[i]   <= '0;
        slot_pri_r[i]  <= '0;
        slot_mode_r[i] <= MODE_OFF;
      end
      plim_r      <= PLIM_RST;
      wlim_r      <= WLIM_RST;
      latch_r     <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      best_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_POWER_LIMIT)   plim_r <= cfg_wdata[TOTAL_W-1:0];
        if (cfg_index == REG_WARNING_LIMIT) wlim_r <= cfg_wdata[TOTAL_W-1:0];
      end

      if (cmd.latch_in) begin
        op_r    <= in_data.operation;
        id_r    <= in_data.device_id;
        np_r    <= POWER_BITS'(in_data.normal_power);
        lp_r    <= POWER_BITS'(in_data.limited_power);
        pr_r    <= in_data.priority_req;
        md_r    <= in_data.mode;
        match_r <= 1'b0;
        free_r  <= 1'b0;
        err_r   <= ERR_OK;
        ev_r    <= 1'b0;
      end

      if (cmd.walk_clr)       idx_r <= '0;
      else if (cmd.walk_step) idx_r <= idx_r + IDX_W'(1);
      if (cmd.walk_clr) best_r <= 1'b0;

      if (cmd.find_step) begin
        if (!match_r && id_r != 16'd0 && cur_id == id_r) begin
          match_r     <= 1'b1;
          match_idx_r <= idx_r;
        end
        if (!free_r && cur_id == 16'd0) begin
          free_r     <= 1'b1;
          free_idx_r <= idx_r;
        end
      end

      if (cmd.apply) begin
        case (op_r)
          OP_CONNECT: begin
            if (id_r == 16'd0) err_r <= ERR_UNKNOWN;
            else if (!match_r && !free_r) err_r <= ERR_FULL;
            else begin
              slot_id_r[tgt]   <= id_r;
              slot_np_r[tgt]   <= np_r;
              slot_lp_r[tgt]   <= lp_r;
              slot_pri_r[tgt]  <= pr_r;
              slot_mode_r[tgt] <= MODE_OFF;
            end
          end
          OP_SET_MODE: begin
            if (!match_r) err_r <= ERR_UNKNOWN;
            else if (md_r != 2'd3) slot_mode_r[match_idx_r] <= md_r;
          end
          OP_DISCONNECT: begin
            if (!match_r) err_r <= ERR_UNKNOWN;
            else begin
              slot_id_r[match_idx_r]   <= '0;
              slot_np_r[match_idx_r]   <= '0;
              slot_lp_r[match_idx_r]   <= '0;
              slot_pri_r[match_idx_r]  <= '0;
              slot_mode_r[match_idx_r] <= MODE_OFF;
            end
          end
          default: ;
        endcase
      end

      if (cmd.sum_step) acc_r <= acc_nxt;

      if (cmd.classify) begin
        lvl_r <= lvl_new;
        if (lvl_new == LVL_LOW) latch_r <= 1'b0;
        else if (!latch_r) begin
          latch_r <= 1'b1;
          ev_r    <= 1'b1;
        end
      end

      if (cmd.scan_step && take) begin
        best_r     <= 1'b1;
        best_idx_r <= idx_r;
        best_pow_r <= cur_pow;
        best_pri_r <= cur_pri;
      end

      // load a new result if one is due, else drain a transfer
      if (cmd.lim_emit || cmd.shed_emit || cmd.stat_emit) out_valid_r <= 1'b1;
      else if (!out_stall)                                out_valid_r <= 1'b0;
      if (cmd.lim_emit) begin
        slot_mode_r[idx_r] <= MODE_LIMITED;
        out_r <= '{kind: KIND_CMD, target_id: cur_id, new_mode: MODE_LIMITED,
                   default: '0};
      end
      if (cmd.shed_emit) begin
        slot_mode_r[best_idx_r] <= MODE_OFF;
        out_r <= '{kind: KIND_CMD, target_id: slot_id_r[best_idx_r], new_mode: MODE_OFF,
                   default: '0};
      end
      if (cmd.stat_emit) begin
        out_r <= '{kind: KIND_STATUS, target_id: 16'd0, new_mode: MODE_OFF,
                   total_power: acc_r, level: lvl_r, warning_event: ev_r,
                   error: err_r, last: 1'b1};
      end
    end
  end

  `PLSC_ASSERT_IMP(a_emit_free, clk, rst_n, (cmd.lim_emit || cmd.shed_emit || cmd.stat_emit), sts.out_free, "result loaded while the output register is busy")
  `PLSC_ASSERT_IMP(a_emit_one, clk, rst_n, 1'b1, $onehot0({cmd.lim_emit, cmd.shed_emit, cmd.stat_emit}), "two results loaded in one cycle")
  `PLSC_ASSERT_IMP(a_shed_live, clk, rst_n, cmd.shed_emit, (slot_id_r[best_idx_r] != 16'd0 && slot_mode_r[best_idx_r] != MODE_OFF), "shedding a load that is free or already off")
  `PLSC_ASSERT_NXT(a_err_code, clk, rst_n, cmd.apply, (err_r == ERR_OK || err_r == ERR_FULL || err_r == ERR_UNKNOWN), "illegal error code after apply")

endmodule

@@ rtl/priority_load_shedding_controller.sv @@
// Top level: priority load shedding controller (sequencer plus datapath)
// Flow: an item without shedding passes an id lookup walk, the apply step, a sum walk,
// classify and the status report. An overload tick adds a limit pass, a re-sum and a check,
// then per shed load a scan walk, the shed command, a re-sum and a check, and a final scan
// when nothing is left on; result stalls hold the sequence.
// Reset (synchronous, rst_n low): table cleared, limits 5000/4500, warning latch clear.
`timescale 1ns / 1ps
module priority_load_shedding_controller #(
  parameter int MAX_LOADS  = plsc_pkg::MAX_LOADS_DEF,
  parameter int POWER_BITS = plsc_pkg::POWER_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  plsc_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output plsc_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [plsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [plsc_pkg::CFG_W-1:0]     cfg_wdata
);
  import plsc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer: accepts a transfer only when idle, then steps the table walks.
  plsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: holds the table, sums power, picks the load to shed and
  // keeps the result register so a finished result waits without blocking.
  plsc_dp #(
    .MAX_LOADS  (MAX_LOADS),
    .POWER_BITS (POWER_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

@@ dv/priority_load_shedding_controller_test.sv @@
// Testbench: load shedding controller checked against a behavioral model of its load table
`timescale 1ns / 1ps
module priority_load_shedding_controller_test;
  import plsc_pkg::*;

  localparam int NLOADS = MAX_LOADS_DEF;
  // Idle time before a register write and before the end of the run
  localparam int SETTLE = 2 * NLOADS + 16;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  priority_load_shedding_controller u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the load table, the limits and the warning latch
  logic [15:0]        tbl_id   [NLOADS];
  logic [15:0]        tbl_np   [NLOADS];
  logic [15:0]        tbl_lp   [NLOADS];
  logic [7:0]         tbl_pri  [NLOADS];
  logic [1:0]         tbl_mode [NLOADS];
  logic               warn_latch;
  logic [TOTAL_W-1:0] lim_over;
  logic [TOTAL_W-1:0] lim_warn;

  out_item_t pending_q[$];   // expected transfers on the result side, oldest first
  int        errors = 0;
  int        items_sent = 0;
  int        results_seen = 0;
  int        sheds_seen = 0;
  bit        idle_en = 1'b1;
  bit        hold_req = 1'b0;

  function automatic logic [15:0] draw_of(int s);
    if (tbl_mode[s] == MODE_NORMAL) return tbl_np[s];
    if (tbl_mode[s] == MODE_LIMITED) return tbl_lp[s];
    return 16'd0;
  endfunction

  // Sum with saturation at the top of the 20-bit total
  function automatic logic [TOTAL_W-1:0] total_draw();
    logic [TOTAL_W:0] t;
    t = '0;
    for (int s = 0; s < NLOADS; s++) begin
      t = t + draw_of(s);
      if (t > TOTAL_MAX) t = TOTAL_MAX;
    end
    return t[TOTAL_W-1:0];
  endfunction

  function automatic int slot_of(logic [15:0] id);
    if (id == 16'd0) return -1;
    for (int s = 0; s < NLOADS; s++) if (tbl_id[s] == id) return s;
    return -1;
  endfunction

  // Slot a sheds ahead of slot b; priority zero means an infinite ratio
  function automatic bit sheds_first(int a, int b);
    logic [31:0] pa, pb;
    pa = draw_of(a);
    pb = draw_of(b);
    if (tbl_pri[b] == 8'd0) return 1'b0;
    if (tbl_pri[a] == 8'd0) return 1'b1;
    return pa * tbl_pri[b] > pb * tbl_pri[a];
  endfunction

  function automatic out_item_t mode_cmd(logic [15:0] id, logic [1:0] m);
    out_item_t c;
    c = '0;
    c.kind = KIND_CMD;
    c.target_id = id;
    c.new_mode = m;
    return c;
  endfunction

  // Advance the shadow table by one accepted item and queue its results
  task automatic apply_item(input in_item_t it, output out_item_t st);
    int                 s;
    int                 best;
    logic [1:0]         err;
    logic [1:0]         lvl;
    logic               ev;
    logic [TOTAL_W-1:0] tot;
    err = ERR_OK;
    ev = 1'b0;
    case (it.operation)
      OP_CONNECT: begin
        if (it.device_id == 16'd0) begin
          err = ERR_UNKNOWN;
        end else begin
          s = slot_of(it.device_id);
          if (s < 0) begin
            for (int k = NLOADS - 1; k >= 0; k--) if (tbl_id[k] == 16'd0) s = k;
          end
          if (s < 0) begin
            err = ERR_FULL;
          end else begin
            tbl_id[s] = it.device_id;
            tbl_np[s] = it.normal_power;
            tbl_lp[s] = it.limited_power;
            tbl_pri[s] = it.priority_req;
            tbl_mode[s] = MODE_OFF;
          end
        end
      end
      OP_SET_MODE: begin
        s = slot_of(it.device_id);
        if (s < 0) err = ERR_UNKNOWN;
        else if (it.mode != 2'd3) tbl_mode[s] = it.mode;   // code 3 keeps the mode
      end
      OP_DISCONNECT: begin
        s = slot_of(it.device_id);
        if (s < 0) begin
          err = ERR_UNKNOWN;
        end else begin
          tbl_id[s] = '0;
          tbl_np[s] = '0;
          tbl_lp[s] = '0;
          tbl_pri[s] = '0;
          tbl_mode[s] = MODE_OFF;
        end
      end
      default: ;
    endcase

    tot = total_draw();
    lvl = (tot >= lim_over) ? LVL_OVER : (tot >= lim_warn) ? LVL_WARN : LVL_LOW;
    if (lvl == LVL_LOW) begin
      warn_latch = 1'b0;
    end else if (!warn_latch) begin
      warn_latch = 1'b1;
      ev = 1'b1;
    end

    if (it.operation == OP_TICK && lvl == LVL_OVER) begin
      // Drop every normal load to limited, in slot order
      for (int k = 0; k < NLOADS; k++) begin
        if (tbl_id[k] != 16'd0 && tbl_mode[k] == MODE_NORMAL) begin
          tbl_mode[k] = MODE_LIMITED;
          pending_q.push_back(mode_cmd(tbl_id[k], MODE_LIMITED));
        end
      end
      // Switch off the worst ratio while still over; stop when nothing is on
      while (total_draw() >= lim_over) begin
        best = -1;
        for (int k = 0; k < NLOADS; k++) begin
          if (tbl_id[k] == 16'd0 || tbl_mode[k] == MODE_OFF) continue;
          if (best < 0 || sheds_first(k, best)) best = k;
        end
        if (best < 0) break;
        tbl_mode[best] = MODE_OFF;
        pending_q.push_back(mode_cmd(tbl_id[best], MODE_OFF));
      end
      tot = total_draw();
    end

    st = '0;
    st.kind = KIND_STATUS;
    st.total_power = tot;
    st.level = lvl;
    st.warning_event = ev;
    st.error = err;
    st.last = 1'b1;
    pending_q.push_back(st);
  endtask

  // Offer one item, hold it until the transfer, then maybe leave a gap
  task automatic offer(input in_item_t it, output out_item_t st);
    int gap;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_item(it, st);
    items_sent++;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain the block, then write one limit register
  task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_POWER_LIMIT) lim_over = val;
    else lim_warn = val;
  endtask

  function automatic in_item_t mk(logic [1:0] op, logic [15:0] id, logic [15:0] np,
                                  logic [15:0] lp, logic [7:0] pr, logic [1:0] m);
    in_item_t it;
    it.operation = op;
    it.device_id = id;
    it.normal_power = np;
    it.limited_power = lp;
    it.priority_req = pr;
    it.mode = m;
    return it;
  endfunction

  // Mostly a small id pool so loads get reused, overwritten and the table fills
  function automatic in_item_t rand_item();
    in_item_t   it;
    int         r;
    r = $urandom_range(0, 99);
    it.operation = (r < 30) ? OP_CONNECT : (r < 65) ? OP_SET_MODE :
                   (r < 75) ? OP_DISCONNECT : OP_TICK;
    r = $urandom_range(0, 9);
    it.device_id = (r == 0) ? 16'd0 : (r == 1) ? 16'($urandom) : 16'($urandom_range(1, 20));
    it.normal_power = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2500));
    it.limited_power = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 900));
    it.priority_req = ($urandom_range(0, 6) == 0) ? 8'd0 : 8'($urandom);
    it.mode = 2'($urandom_range(0, 3));
    return it;
  endfunction

  task automatic run_random(int n);
    out_item_t st;
    for (int i = 0; i < n; i++) offer(rand_item(), st);
  endtask

  // Fill the free slots from the lowest up, then connect past a full table
  task automatic fill_table();
    out_item_t st;
    for (int i = 0; i <= NLOADS; i++) begin
      offer(mk(OP_CONNECT, 16'(100 + i), 16'($urandom_range(0, 1500)),
               16'($urandom_range(0, 500)), 8'($urandom), MODE_OFF), st);
      offer(mk(OP_SET_MODE, 16'(100 + i), '0, '0, '0, 2'($urandom_range(1, 2))), st);
    end
  endtask

  // Directed rows; chk marks rows whose status is obvious and typed in
  typedef struct {
    in_item_t           it;
    bit                 chk;
    logic [1:0]         err;
    logic [TOTAL_W-1:0] tot;
    logic [1:0]         lvl;
  } row_t;

  row_t rows[$];

  task automatic run_directed();
    out_item_t st;
    rows = '{
      '{mk(OP_TICK,       16'd0,     16'd0,     16'd0,     8'd0,   MODE_OFF),    1, ERR_OK, 0, LVL_LOW},
      '{mk(OP_CONNECT,    16'd0,     16'd100,   16'd50,    8'd5,   MODE_OFF),    1, ERR_UNKNOWN, 0, LVL_LOW},
      '{mk(OP_SET_MODE,   16'd5,     16'd0,     16'd0,     8'd0,   MODE_NORMAL), 1, ERR_UNKNOWN, 0, LVL_LOW},
      '{mk(OP_DISCONNECT, 16'hFFFF,  16'd0,     16'd0,     8'd0,   MODE_OFF),    1, ERR_UNKNOWN, 0, LVL_LOW},
      '{mk(OP_SET_MODE,   16'd0,     16'd0,     16'd0,     8'd0,   MODE_NORMAL), 1, ERR_UNKNOWN, 0, LVL_LOW},
      '{mk(OP_CONNECT,    16'd1,     16'd3000,  16'd1000,  8'd10,  MODE_OFF),    1, ERR_OK, 0, LVL_LOW},
      '{mk(OP_CONNECT,    16'd2,     16'd2000,  16'd500,   8'd0,   MODE_OFF),    1, ERR_OK, 0, LVL_LOW},
      '{mk(OP_CONNECT,    16'hFFFF,  16'hFFFF,  16'hFFFF,  8'hFF,  2'd3),        1, ERR_OK, 0, LVL_LOW},
      '{mk(OP_SET_MODE,   16'd1,     16'd0,     16'd0,     8'd0,   MODE_NORMAL), 1, ERR_OK, 3000, LVL_LOW},
      '{mk(OP_SET_MODE,   16'd2,     16'd0,     16'd0,     8'd0,   MODE_NORMAL), 1, ERR_OK, 5000, LVL_OVER},
      '{mk(OP_TICK,       16'd7,     16'd0,     16'd0,     8'd0,   MODE_OFF),    0, ERR_OK, 0, LVL_LOW},
      '{mk(OP_SET_MODE,   16'd1,     16'd0,     16'd0,     8'd0,   2'd3),        0, ERR_OK, 0, LVL_LOW},
      '{mk(OP_SET_MODE,   16'hFFFF,  16'd0,     16'd0,     8'd0,   MODE_NORMAL), 0, ERR_OK, 0, LVL_LOW},
      '{mk(OP_SET_MODE,   16'd1,     16'd0,     16'd0,     8'd0,   MODE_NORMAL), 0, ERR_OK, 0, LVL_LOW},
      '{mk(OP_TICK,       16'd0,     16'd0,     16'd0,     8'd0,   MODE_OFF),    0, ERR_OK, 0, LVL_LOW},
      '{mk(OP_SET_MODE,   16'd2,     16'd0,     16'd0,     8'd0,   MODE_LIMITED),0, ERR_OK, 0, LVL_LOW},
      '{mk(OP_SET_MODE,   16'd1,     16'd0,     16'd0,     8'd0,   MODE_LIMITED),0, ERR_OK, 0, LVL_LOW},
      '{mk(OP_CONNECT,    16'd1,     16'd4000,  16'd4000,  8'd1,   MODE_NORMAL), 0, ERR_OK, 0, LVL_LOW},
      '{mk(OP_SET_MODE,   16'd1,     16'd0,     16'd0,     8'd0,   MODE_NORMAL), 0, ERR_OK, 0, LVL_LOW},
      '{mk(OP_TICK,       16'd0,     16'd0,     16'd0,     8'd0,   MODE_OFF),    0, ERR_OK, 0, LVL_LOW},
      '{mk(OP_DISCONNECT, 16'd2,     16'd0,     16'd0,     8'd0,   MODE_OFF),    0, ERR_OK, 0, LVL_LOW},
      '{mk(OP_DISCONNECT, 16'hFFFF,  16'd0,     16'd0,     8'd0,   MODE_OFF),    0, ERR_OK, 0, LVL_LOW}
    };
    foreach (rows[i]) begin
      offer(rows[i].it, st);
      if (rows[i].chk && (st.error !== rows[i].err || st.total_power !== rows[i].tot ||
                          st.level !== rows[i].lvl)) begin
        $error("directed row %0d: expected err %0d total %0d level %0d, model gives %0d %0d %0d",
               i, rows[i].err, rows[i].tot, rows[i].lvl, st.error, st.total_power, st.level);
        errors++;
      end
    end
  endtask

  // Result side: compare every transfer with the oldest expectation
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        $error("unexpected result transfer: %p", out_data);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (e.kind == KIND_CMD && e.new_mode == MODE_OFF) sheds_seen++;
        if (out_data.kind !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, out_data.kind); errors++;
        end
        if (out_data.target_id !== e.target_id) begin
          $error("target_id: expected %0d, got %0d", e.target_id, out_data.target_id); errors++;
        end
        if (out_data.new_mode !== e.new_mode) begin
          $error("new_mode: expected %0d, got %0d", e.new_mode, out_data.new_mode); errors++;
        end
        if (out_data.total_power !== e.total_power) begin
          $error("total_power: expected %0d, got %0d", e.total_power, out_data.total_power);
          errors++;
        end
        if (out_data.level !== e.level) begin
          $error("level: expected %0d, got %0d", e.level, out_data.level); errors++;
        end
        if (out_data.warning_event !== e.warning_event) begin
          $error("warning_event: expected %0d, got %0d", e.warning_event,
                 out_data.warning_event);
          errors++;
        end
        if (out_data.error !== e.error) begin
          $error("error: expected %0d, got %0d", e.error, out_data.error); errors++;
        end
        if (out_data.last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, out_data.last); errors++;
        end
      end
    end
  end

  // Result side stall: random bursts, plus one long hold-off on request
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 9);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    for (int s = 0; s < NLOADS; s++) begin
      tbl_id[s] = '0; tbl_np[s] = '0; tbl_lp[s] = '0; tbl_pri[s] = '0; tbl_mode[s] = MODE_OFF;
    end
    warn_latch = 1'b0;
    lim_over = PLIM_RST;
    lim_warn = WLIM_RST;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset limits: hand-checked rows first
    run_directed();

    // Mid limits; hold the result side so the block backs up its input
    write_limit(REG_POWER_LIMIT, 20'd3000);
    write_limit(REG_WARNING_LIMIT, 20'd2000);
    hold_req = 1'b1;
    fill_table();
    run_random(15);

    // Zero limits: every item is overload, every tick sheds all
    write_limit(REG_POWER_LIMIT, 20'd0);
    write_limit(REG_WARNING_LIMIT, 20'd0);
    run_random(10);

    // Top limits: nothing ever reaches them
    write_limit(REG_POWER_LIMIT, TOTAL_MAX);
    write_limit(REG_WARNING_LIMIT, TOTAL_MAX);
    run_random(10);

    // Warning above overload, then a final stretch with no idling
    write_limit(REG_POWER_LIMIT, 20'd4000);
    write_limit(REG_WARNING_LIMIT, 20'd6000);
    run_random(10);
    idle_en = 1'b0;
    run_random(15);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Covered %0d items, %0d result transfers, %0d loads switched off,",
             items_sent, results_seen, sheds_seen);
    $display("over five limit settings including zero and full scale.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
